// ===== hw/rtl/stepper_half_step_speed_display_macros.svh =====
// ----------------------------------------------------------------------------
// Stepper half-step speed display assertion macros
// Shared assertion forms used by the checker of the stepper block.
// ----------------------------------------------------------------------------
`ifndef STEPPER_HALF_STEP_SPEED_DISPLAY_MACROS_SVH
`define STEPPER_HALF_STEP_SPEED_DISPLAY_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SHSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SHSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/shsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper half-step speed display package
// Shared types, reset values, lookup tables and the speed digit decode.
// ----------------------------------------------------------------------------
package shsd_pkg;

    localparam int NUM_DIGITS_DEF = 8;

    localparam int IN_W  = 8;
    localparam int OUT_W = 24;
    localparam int CFG_W = 16;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_RUN_CYCLES     = 3'd0,
        CFG_SPEED_LOW      = 3'd1,
        CFG_SPEED_HIGH     = 3'd2,
        CFG_DEBOUNCE_TICKS = 3'd3,
        CFG_SCAN_TICKS     = 3'd4
    } cfg_index_t;

    localparam logic [15:0] RUN_CYCLES_RST     = 16'd512;
    localparam logic [6:0]  SPEED_LOW_RST      = 7'd3;
    localparam logic [6:0]  SPEED_HIGH_RST     = 7'd19;
    localparam logic [7:0]  DEBOUNCE_TICKS_RST = 8'd10;
    localparam logic [3:0]  SCAN_TICKS_RST     = 4'd2;

    localparam logic [3:0] COILS_HOLD = 4'h9;
    localparam logic [2:0] PHASE_LAST = 3'd7;

    // Half-step coil order A, AB, B, BC, C, CD, D, DA.
    localparam logic [3:0] COIL_SEQ [8] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hc, 4'h8, 4'h9
    };

    // Seven-segment font for the decimal digits, bit 0 is segment a.
    localparam logic [7:0] SEG_FONT [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    // Returns the font of the units digit in the upper byte and of the tens
    // digit in the lower byte, for the speed taken modulo 100. The tens digit
    // comes from a multiply by 205/2048, exact for values below 100.
    function automatic logic [15:0] speed_fonts(input logic [6:0] speed);
        logic [6:0]  t;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        t     = (speed >= 7'd100) ? (speed - 7'd100) : speed;
        prod  = 15'(t) * 15'd205;
        tens  = prod[14:11];
        units = t - (7'(tens) * 7'd10);
        return {SEG_FONT[units[3:0]], SEG_FONT[tens]};
    endfunction

endpackage

// ===== hw/rtl/stepper_half_step_speed_display.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper half-step driver with speed display
// Tick-driven half-step sequencer, debounced speed button and scanned
// seven-segment readout of the speed.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[0] button_low, tdata[7:1] zero
//  m_axis    out        tdata[3:0] coils, [11:4] segments, [19:12] digit_select,
//                       [20] done_res, [23:21] zero
//  cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// One item is one millisecond tick; the block takes one item every clock
// cycle while s_axis_tready is high; its result goes to the output stage.
// All motor, debounce and scan state is updated in the cycle the item is
// accepted, from short compare and increment logic.
// A two-entry output stage (output register plus skid register) lets the
// input keep flowing while a result waits; s_axis_tready drops only when both
// entries are full. Reset loads the register defaults and the motor at phase A.
// ----------------------------------------------------------------------------
module stepper_half_step_speed_display
    import shsd_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Input item: bit 0 button_low.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,
    // Result item: coils, segments, digit_select, done_res from bit 0 up.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,
    // Configuration write port.
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(NUM_DIGITS);

    // Configuration registers.
    logic [15:0] run_cycles_reg, run_cycles_next;
    logic [6:0]  speed_low_reg, speed_low_next;
    logic [6:0]  speed_high_reg, speed_high_next;
    logic [7:0]  debounce_ticks_reg, debounce_ticks_next;
    logic [3:0]  scan_ticks_reg, scan_ticks_next;

    // Tick state.
    logic [2:0]       phase_reg, phase_next;
    logic [6:0]       phase_ticks_reg, phase_ticks_next;
    logic [15:0]      cycles_left_reg, cycles_left_next;
    logic [6:0]       speed_reg, speed_next;
    logic [7:0]       debounce_count_reg, debounce_count_next;
    logic             debounce_busy_reg, debounce_busy_next;
    logic             button_prev_reg, button_prev_next;
    logic [IDX_W-1:0] scan_index_reg, scan_index_next;
    logic [3:0]       scan_count_reg, scan_count_next;
    logic             finished_reg, finished_next;

    // Output stage.
    logic             out_valid_reg, skid_valid_reg;
    logic [OUT_W-1:0] out_data_reg, skid_data_reg;

    logic             accept;
    logic             out_take;
    logic             button;
    logic [7:0]       segments;
    logic [7:0]       digit_select;
    logic [3:0]       coils;
    logic [OUT_W-1:0] result;

    // Intermediate arithmetic.
    logic [7:0]  phase_ticks_inc;
    logic [15:0] cycles_dec;
    logic [7:0]  debounce_inc;
    logic [7:0]  speed_inc;
    logic [4:0]  scan_inc;

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_take      = out_valid_reg && m_axis_tready;
    assign button        = s_axis_tdata[0];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // The result is formed from the state as it stands before this item.
    shsd_display #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_display (
        .speed        (speed_reg),
        .scan_index   (scan_index_reg),
        .segments     (segments),
        .digit_select (digit_select)
    );

    assign coils  = finished_reg ? COILS_HOLD : COIL_SEQ[phase_reg];
    assign result = {3'b000, finished_reg, digit_select, segments, coils};

    assign phase_ticks_inc = {1'b0, phase_ticks_reg} + 8'd1;
    assign cycles_dec      = cycles_left_reg - 16'd1;
    assign debounce_inc    = debounce_count_reg + 8'd1;
    assign speed_inc       = {1'b0, speed_reg} + 8'd1;
    assign scan_inc        = {1'b0, scan_count_reg} + 5'd1;

    always_comb
    begin
        run_cycles_next     = run_cycles_reg;
        speed_low_next      = speed_low_reg;
        speed_high_next     = speed_high_reg;
        debounce_ticks_next = debounce_ticks_reg;
        scan_ticks_next     = scan_ticks_reg;

        phase_next          = phase_reg;
        phase_ticks_next    = phase_ticks_reg;
        cycles_left_next    = cycles_left_reg;
        speed_next          = speed_reg;
        debounce_count_next = debounce_count_reg;
        debounce_busy_next  = debounce_busy_reg;
        button_prev_next    = button_prev_reg;
        scan_index_next     = scan_index_reg;
        scan_count_next     = scan_count_reg;
        finished_next       = finished_reg;

        if (accept)
        begin
            // Motor: a phase ends once its tick count reaches the speed, so a
            // lowered speed cuts the running phase short.
            if (!finished_reg)
            begin
                if (phase_ticks_inc >= {1'b0, speed_reg})
                begin
                    phase_ticks_next = 7'd0;
                    if (phase_reg == PHASE_LAST)
                    begin
                        phase_next       = 3'd0;
                        cycles_left_next = cycles_dec;
                        if (cycles_dec == 16'd0)
                        begin
                            finished_next = 1'b1;
                            phase_next    = PHASE_LAST;
                        end
                    end
                    else
                    begin
                        phase_next = phase_reg + 3'd1;
                    end
                end
                else
                begin
                    phase_ticks_next = phase_ticks_inc[6:0];
                end
            end

            // Debounce: a falling edge opens the wait; the sample at its end
            // decides whether the speed steps. Edges during the wait are lost.
            if (debounce_busy_reg)
            begin
                debounce_count_next = debounce_inc;
                if (debounce_inc >= debounce_ticks_reg)
                begin
                    debounce_busy_next  = 1'b0;
                    debounce_count_next = 8'd0;
                    if (!button)
                    begin
                        if (speed_inc > {1'b0, speed_high_reg})
                        begin
                            speed_next = speed_low_reg;
                        end
                        else
                        begin
                            speed_next = speed_inc[6:0];
                        end
                    end
                end
            end
            else if (button_prev_reg && !button)
            begin
                debounce_busy_next  = 1'b1;
                debounce_count_next = 8'd0;
            end

            // Display scan.
            if (scan_inc >= {1'b0, scan_ticks_reg})
            begin
                scan_count_next = 4'd0;
                if (scan_index_reg == IDX_W'(NUM_DIGITS - 1))
                begin
                    scan_index_next = '0;
                end
                else
                begin
                    scan_index_next = scan_index_reg + IDX_W'(1);
                end
            end
            else
            begin
                scan_count_next = scan_inc[3:0];
            end

            button_prev_next = button;
        end

        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_RUN_CYCLES:
                begin
                    run_cycles_next  = cfg_data;
                    phase_next       = 3'd0;
                    phase_ticks_next = 7'd0;
                    cycles_left_next = cfg_data;
                    finished_next    = (cfg_data == 16'd0);
                end
                CFG_SPEED_LOW:
                begin
                    speed_low_next = cfg_data[6:0];
                    speed_next     = cfg_data[6:0];
                end
                CFG_SPEED_HIGH:
                begin
                    speed_high_next = cfg_data[6:0];
                end
                CFG_DEBOUNCE_TICKS:
                begin
                    debounce_ticks_next = cfg_data[7:0];
                end
                CFG_SCAN_TICKS:
                begin
                    scan_ticks_next = cfg_data[3:0];
                end
                default:
                begin
                    run_cycles_next = run_cycles_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cycles_reg     <= RUN_CYCLES_RST;
            speed_low_reg      <= SPEED_LOW_RST;
            speed_high_reg     <= SPEED_HIGH_RST;
            debounce_ticks_reg <= DEBOUNCE_TICKS_RST;
            scan_ticks_reg     <= SCAN_TICKS_RST;
            phase_reg          <= 3'd0;
            phase_ticks_reg    <= 7'd0;
            cycles_left_reg    <= RUN_CYCLES_RST;
            speed_reg          <= SPEED_LOW_RST;
            debounce_count_reg <= 8'd0;
            debounce_busy_reg  <= 1'b0;
            button_prev_reg    <= 1'b1;
            scan_index_reg     <= '0;
            scan_count_reg     <= 4'd0;
            finished_reg       <= (RUN_CYCLES_RST == 16'd0);
        end
        else
        begin
            run_cycles_reg     <= run_cycles_next;
            speed_low_reg      <= speed_low_next;
            speed_high_reg     <= speed_high_next;
            debounce_ticks_reg <= debounce_ticks_next;
            scan_ticks_reg     <= scan_ticks_next;
            phase_reg          <= phase_next;
            phase_ticks_reg    <= phase_ticks_next;
            cycles_left_reg    <= cycles_left_next;
            speed_reg          <= speed_next;
            debounce_count_reg <= debounce_count_next;
            debounce_busy_reg  <= debounce_busy_next;
            button_prev_reg    <= button_prev_next;
            scan_index_reg     <= scan_index_next;
            scan_count_reg     <= scan_count_next;
            finished_reg       <= finished_next;
        end
    end

    // Output stage: the skid register catches a result that arrives while
    // the output register is held by a stalled consumer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_take)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= accept;
                end
            end
            else if (accept)
            begin
                if (out_valid_reg)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (accept && (out_take || !out_valid_reg))
        begin
            out_data_reg <= result;
        end

        if (accept && out_valid_reg && !out_take)
        begin
            skid_data_reg <= result;
        end
    end

endmodule

// ===== hw/rtl/shsd_display.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed display decode
// Segment pattern and one-cold digit enable for the current scan position.
// ----------------------------------------------------------------------------
module shsd_display
    import shsd_pkg::*;
#(
    parameter int NUM_DIGITS = NUM_DIGITS_DEF,
    localparam int IDX_W = $clog2(NUM_DIGITS)
)
(
    input  logic [6:0]       speed,
    input  logic [IDX_W-1:0] scan_index,
    output logic [7:0]       segments,
    output logic [7:0]       digit_select
);

    logic [15:0] fonts;

    assign fonts = speed_fonts(speed);

    // Only the first two positions carry digits; the rest stay blank.
    always_comb
    begin
        if (scan_index == IDX_W'(0))
        begin
            segments = fonts[7:0];
        end
        else if (scan_index == IDX_W'(1))
        begin
            segments = fonts[15:8];
        end
        else
        begin
            segments = 8'h00;
        end
    end

    assign digit_select = ~(8'd1 << scan_index);

endmodule

// ===== hw/rtl/shsd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper half-step speed display checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "stepper_half_step_speed_display_macros.svh"

module shsd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    `SHSD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `SHSD_ASSERT_NOW(a_one_cold, clk, rst_n, m_axis_tvalid, $onehot(~m_axis_tdata[19:12]), "digit select is not one-cold")
    `SHSD_ASSERT_NOW(a_done_hold, clk, rst_n, m_axis_tvalid && m_axis_tdata[20], m_axis_tdata[3:0] == 4'h9, "coils not held at DA when done")
    `SHSD_ASSERT_NOW(a_coil_pattern, clk, rst_n, m_axis_tvalid, ($countones(m_axis_tdata[3:0]) == 1) || ($countones(m_axis_tdata[3:0]) == 2), "coil pattern is not a half step")
    `SHSD_ASSERT_NOW(a_blank_digits, clk, rst_n, m_axis_tvalid && (m_axis_tdata[13:12] == 2'b11), m_axis_tdata[11:4] == 8'h00, "blank position shows segments")

endmodule

bind stepper_half_step_speed_display shsd_checker u_shsd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper half-step speed display testbench
// Sends button ticks through the input stream and checks every result item
// against an in-bench prediction of the coil drive, the scanned display and
// the done flag. Directed corner runs come first, then register settings
// with random press traffic under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module testbench;

    import shsd_pkg::*;

    localparam int DISPLAY_DIGITS = 8;
    localparam int RES_W          = 21;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_TICKS    = 135;
    localparam int MAX_REPORTS    = 60;

    localparam logic [2:0] LAST_PHASE   = 3'd7;
    localparam logic [3:0] COIL_HOLD_DA = 4'h9;

    // Coil drive bits for A, AB, B, BC, C, CD, D, DA.
    localparam logic [3:0] COIL_ORDER [8] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hc, 4'h8, 4'h9
    };
    // Decimal digit patterns, segment a in bit 0.
    localparam logic [7:0] DIGIT_FONT [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };
    // Active-low enable for each scan position.
    localparam logic [7:0] DIGIT_ENABLE [8] = '{
        8'hfe, 8'hfd, 8'hfb, 8'hf7, 8'hef, 8'hdf, 8'hbf, 8'h7f
    };

    // Sink-side ready patterns.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC
    } rx_pattern_t;

    // One result item as it sits in m_axis_tdata, lowest field last here.
    typedef struct packed {
        logic       done_res;
        logic [7:0] digit_select;
        logic [7:0] segments;
        logic [3:0] coils;
    } drive_word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              cfg_we = 1'b0;
    logic [2:0]        cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;

    // Register copy kept by the prediction.
    logic [15:0] cfg_run_cycles;
    logic [6:0]  cfg_speed_low;
    logic [6:0]  cfg_speed_high;
    logic [7:0]  cfg_debounce;
    logic [3:0]  cfg_scan;

    // Predicted block state.
    logic [2:0]  motor_phase;
    logic [6:0]  phase_ticks;
    logic [15:0] cycles_left;
    logic [6:0]  cur_speed;
    logic [7:0]  debounce_count;
    logic        debounce_busy;
    logic        button_prev;
    logic [2:0]  scan_pos;
    logic [3:0]  scan_count;
    logic        run_done;

    // Drive words still owed by the block, oldest first.
    drive_word_t expected_drive [$];

    int error_count = 0;
    int cycle_count = 0;
    int ticks_sent  = 0;
    int burst_left  = 0;
    int rx_left     = 0;
    rx_pattern_t rx_mode = RX_ALWAYS;

    stepper_half_step_speed_display #(
        .NUM_DIGITS (DISPLAY_DIGITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // bit 0 button_low, upper bits zero
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // coils, segments, digit_select, done_res
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // A hung handshake or a lost result ends the run here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // The motor goes back to phase A with a fresh cycle count; a count of
    // zero means it is finished before it ever steps.
    function automatic void restart_motor();
        motor_phase = '0;
        phase_ticks = '0;
        cycles_left = cfg_run_cycles;
        run_done    = (cfg_run_cycles == 16'd0);
    endfunction

    function automatic void reset_prediction();
        cfg_run_cycles = RUN_CYCLES_RST;
        cfg_speed_low  = SPEED_LOW_RST;
        cfg_speed_high = SPEED_HIGH_RST;
        cfg_debounce   = DEBOUNCE_TICKS_RST;
        cfg_scan       = SCAN_TICKS_RST;
        restart_motor();
        cur_speed      = cfg_speed_low;
        debounce_count = '0;
        debounce_busy  = 1'b0;
        button_prev    = 1'b1;
        scan_pos       = '0;
        scan_count     = '0;
    endfunction

    // Mirrors a register write. Only run_cycles and speed_low touch state;
    // indexes past the register list are ignored.
    function automatic void load_register(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            CFG_RUN_CYCLES:
            begin
                cfg_run_cycles = data;
                restart_motor();
            end
            CFG_SPEED_LOW:
            begin
                cfg_speed_low = data[6:0];
                cur_speed     = data[6:0];
            end
            CFG_SPEED_HIGH:     cfg_speed_high = data[6:0];
            CFG_DEBOUNCE_TICKS: cfg_debounce   = data[7:0];
            CFG_SCAN_TICKS:     cfg_scan       = data[3:0];
            default:            ;
        endcase
    endfunction

    // One millisecond tick: the outputs come from the state before the
    // update, then motor, debouncer, scan and the button history advance.
    function automatic drive_word_t step_stepper(input logic btn);
        drive_word_t w;
        int          shown;
        int          next_speed;
        shown          = int'(cur_speed) % 100;
        w.coils        = run_done ? COIL_HOLD_DA : COIL_ORDER[motor_phase];
        w.digit_select = DIGIT_ENABLE[scan_pos];
        w.done_res     = run_done;
        if (scan_pos == 3'd0)
            w.segments = DIGIT_FONT[shown / 10];
        else if (scan_pos == 3'd1)
            w.segments = DIGIT_FONT[shown % 10];
        else
            w.segments = 8'h00;

        // A speed of zero still ends the phase every tick, and a speed that
        // dropped mid-phase ends an overlong phase at once.
        if (!run_done)
        begin
            if (int'(phase_ticks) + 1 >= int'(cur_speed))
            begin
                phase_ticks = '0;
                if (motor_phase == LAST_PHASE)
                begin
                    motor_phase = '0;
                    cycles_left = cycles_left - 16'd1;
                    if (cycles_left == 16'd0)
                    begin
                        run_done    = 1'b1;
                        motor_phase = LAST_PHASE;
                    end
                end
                else
                begin
                    motor_phase = motor_phase + 3'd1;
                end
            end
            else
            begin
                phase_ticks = phase_ticks + 7'd1;
            end
        end

        // Falling edges during the wait are ignored; the wrap compares the
        // incremented speed with speed_high even when speed_low is larger.
        if (debounce_busy)
        begin
            debounce_count = debounce_count + 8'd1;
            if (debounce_count >= cfg_debounce)
            begin
                debounce_busy  = 1'b0;
                debounce_count = '0;
                if (!btn)
                begin
                    next_speed = int'(cur_speed) + 1;
                    cur_speed  = (next_speed > int'(cfg_speed_high)) ?
                                 cfg_speed_low : 7'(next_speed);
                end
            end
        end
        else if (button_prev && !btn)
        begin
            debounce_busy  = 1'b1;
            debounce_count = '0;
        end

        if (int'(scan_count) + 1 >= int'(cfg_scan))
        begin
            scan_count = '0;
            scan_pos   = 3'((int'(scan_pos) + 1) % DISPLAY_DIGITS);
        end
        else
        begin
            scan_count = scan_count + 4'd1;
        end

        button_prev = btn;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
    endtask

    // Each accepted result item is held against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        drive_word_t got;
        drive_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = drive_word_t'(m_axis_tdata[RES_W-1:0]);
            if (expected_drive.size() == 0)
            begin
                report_mismatch("result with nothing pending", int'(got), 0);
            end
            else
            begin
                want = expected_drive.pop_front();
                if (got.coils != want.coils)
                    report_mismatch("coils", int'(got.coils), int'(want.coils));
                if (got.segments != want.segments)
                    report_mismatch("segments", int'(got.segments), int'(want.segments));
                if (got.digit_select != want.digit_select)
                    report_mismatch("digit_select", int'(got.digit_select),
                                    int'(want.digit_select));
                if (got.done_res != want.done_res)
                    report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
            end
        end
    end

    // The sink switches between always ready, mostly ready, rarely ready and
    // a fixed duty pattern, each held for a random stretch of cycles.
    always @(posedge clk)
    begin : rx_stall_pattern
        logic ready_next;
        if (rx_left == 0)
        begin
            rx_mode = rx_pattern_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 160);
        end
        else
        begin
            rx_left--;
        end
        case (rx_mode)
            RX_ALWAYS:  ready_next = 1'b1;
            RX_MOSTLY:  ready_next = ($urandom_range(0, 3) != 0);
            RX_SPARSE:  ready_next = ($urandom_range(0, 3) == 0);
            default:    ready_next = ((rx_left % 6) < 2);
        endcase
        m_axis_tready <= ready_next;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Sends one tick item. The source runs in bursts; between bursts it may
    // drop tvalid for a few cycles. The prediction runs at the accepting edge.
    task automatic send_tick(input logic btn);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(btn);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_drive.push_back(step_stepper(btn));
        ticks_sent++;
    endtask

    // Holds the source off until every predicted item has come back.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        load_register(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Fills the bits above a register's width with noise; the block drops them.
    function automatic logic [15:0] with_noise(input logic [15:0] value, input int width);
        logic [15:0] keep;
        keep = (16'hffff >> (16 - width));
        return (value & keep) | (16'($urandom) & ~keep);
    endfunction

    task automatic send_levels(input logic [31:0] levels, input int count);
        for (int i = 0; i < count; i++)
            send_tick(levels[i]);
    endtask

    // Press traffic shaped around the current debounce wait: mostly clean
    // presses held just short of, at, or past the confirming sample, then
    // short taps that release early, and some random chatter.
    task automatic drive_button_traffic(input int n_ticks);
        int stop_at;
        int kind;
        int wait_len;
        int hold;
        stop_at = ticks_sent + n_ticks;
        while (ticks_sent < stop_at)
        begin
            kind     = $urandom_range(0, 9);
            wait_len = (cfg_debounce == 8'd0) ? 1 : int'(cfg_debounce);
            if (kind < 6)
            begin
                hold = wait_len + $urandom_range(0, 2);
                repeat (hold) send_tick(1'b0);
                repeat ($urandom_range(1, 4)) send_tick(1'b1);
            end
            else if (kind < 8)
            begin
                hold = $urandom_range(1, wait_len);
                repeat (hold) send_tick(1'b0);
                repeat ($urandom_range(1, 3)) send_tick(1'b1);
            end
            else
            begin
                repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset register values: speed 3, two ticks per scan position.
    task automatic test_reset_state();
        repeat (6) send_tick(1'b1);
    endtask

    // Zero speed, zero debounce and zero scan all act as one; a single run
    // cycle finishes within a few ticks, and two presses wrap the speed.
    task automatic test_fast_corners();
        wait_results_drained();
        write_register(CFG_RUN_CYCLES, 16'd1);
        write_register(CFG_SPEED_LOW, 16'd0);
        write_register(CFG_SPEED_HIGH, 16'd1);
        write_register(CFG_DEBOUNCE_TICKS, 16'd0);
        write_register(CFG_SCAN_TICKS, 16'd0);
        send_levels(32'b1111_1100_1001, 12);
    endtask

    // Zero run cycles holds DA at once. The speed climbs to 99, then a wrap
    // with speed_low above speed_high, then a speed above 99 on the display.
    // Writes to indexes past the register list must change nothing.
    task automatic test_slow_corners();
        logic [2:0] idx;
        wait_results_drained();
        write_register(CFG_RUN_CYCLES, 16'd0);
        write_register(CFG_SPEED_LOW, 16'd98);
        write_register(CFG_SPEED_HIGH, 16'd127);
        write_register(CFG_DEBOUNCE_TICKS, 16'd1);
        write_register(CFG_SCAN_TICKS, 16'd15);
        send_levels(32'b1001, 4);
        wait_results_drained();
        write_register(CFG_SPEED_HIGH, 16'd5);
        send_levels(32'b100, 3);
        wait_results_drained();
        write_register(CFG_SPEED_LOW, 16'd127);
        idx = CFG_SCAN_TICKS;
        repeat (3)
        begin
            idx = idx + 3'd1;
            write_register(idx, 16'($urandom));
        end
        send_levels(32'b11, 2);
    endtask

    // Several register settings, the extremes first, each followed by press
    // traffic. Halfway through each setting the source waits for the sink
    // to catch up completely.
    task automatic test_random_presses();
        logic [15:0] run_v;
        logic [15:0] low_v;
        logic [15:0] high_v;
        logic [15:0] deb_v;
        logic [15:0] scan_v;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
            begin
                run_v  = 16'hffff;
                low_v  = 16'd127;
                high_v = 16'd127;
                deb_v  = 16'd255;
                scan_v = 16'd15;
            end
            else if (p == 1)
            begin
                run_v  = 16'd1;
                low_v  = 16'd1;
                high_v = 16'd1;
                deb_v  = 16'd1;
                scan_v = 16'd1;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:       run_v = 16'd0;
                    4:       run_v = 16'hffff;
                    5:       run_v = 16'($urandom);
                    default: run_v = 16'($urandom_range(1, 4));
                endcase
                case ($urandom_range(0, 5))
                    0:       low_v = 16'd0;
                    1:       low_v = 16'd99;
                    2:       low_v = 16'($urandom_range(100, 127));
                    default: low_v = 16'($urandom_range(1, 6));
                endcase
                case ($urandom_range(0, 5))
                    0:       high_v = 16'd0;
                    1:       high_v = 16'd127;
                    2:       high_v = 16'($urandom_range(0, 127));
                    default: high_v = 16'($urandom_range(1, 9));
                endcase
                deb_v  = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
                scan_v = 16'($urandom_range(0, 15));
            end
            wait_results_drained();
            write_register(CFG_RUN_CYCLES, run_v);
            write_register(CFG_SPEED_LOW, with_noise(low_v, 7));
            write_register(CFG_SPEED_HIGH, with_noise(high_v, 7));
            write_register(CFG_DEBOUNCE_TICKS, with_noise(deb_v, 8));
            write_register(CFG_SCAN_TICKS, with_noise(scan_v, 4));
            drive_button_traffic(PHASE_TICKS / 2);
            wait_results_drained();
            drive_button_traffic(PHASE_TICKS - PHASE_TICKS / 2);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        reset_prediction();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_fast_corners();
        test_slow_corners();
        test_random_presses();

        // Results pass through the registered output stage, so a short settle after the
        // queue empties is enough to catch any stray extra item.
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/shsd_pkg.sv
hw/rtl/shsd_display.sv
hw/rtl/stepper_half_step_speed_display.sv
hw/rtl/shsd_checker.sv
sim/testbench.sv
